// File: rtl/max_tree_threshold_search_unit_assert.svh
// assertion macros for the max tree threshold search unit
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef MAX_TREE_THRESHOLD_SEARCH_UNIT_ASSERT_SVH
`define MAX_TREE_THRESHOLD_SEARCH_UNIT_ASSERT_SVH

// plain property checked on every clock outside reset
`define MTTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define MTTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/mtts_pkg.sv
// shared types and constants of the max tree threshold search unit
// no dependencies
package mtts_pkg;

  localparam int unsigned LEAVES    = 1024;
  localparam int unsigned TREE_SIZE = 2 * LEAVES;
  localparam int unsigned IDX_W     = $clog2(TREE_SIZE);
  localparam int unsigned POS_W     = 11;
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned STACK_D   = 16;
  localparam int unsigned SP_W      = $clog2(STACK_D);

  typedef enum logic [1:0] {
    REQ_WRITE      = 2'd0,
    REQ_FIND_RIGHT = 2'd1,
    REQ_FIND_LEFT  = 2'd2,
    REQ_CLEAR      = 2'd3
  } req_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] write_value;
    logic [POS_W-1:0] range_low;
    logic [POS_W-1:0] range_high;
    logic [VAL_W-1:0] threshold;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] found_position;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// File: rtl/mtts_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module mtts_ram #(
  parameter int unsigned Depth = 2048,
  parameter int unsigned Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/mtts_ctrl.sv
// sequencer: clear sweep, leaf write with refresh to the root, tree search
// depends on mtts_pkg and max_tree_threshold_search_unit_assert.svh
`include "max_tree_threshold_search_unit_assert.svh"
module mtts_ctrl import mtts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  req_t             req_i,
  input  logic [POS_W-1:0] span_i,
  output mem_req_t         mem_o,
  input  logic [VAL_W-1:0] rdata_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_WDESC, S_WREAD, S_WUPD, S_QVISIT, S_QCHECK, S_RESULT
  } state_e;

  typedef struct packed {
    logic [IDX_W-1:0] node;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
  } frame_t;

  state_e           state_q;
  logic [IDX_W-1:0] node_q;
  logic [POS_W-1:0] lo_q, hi_q;
  logic [VAL_W-1:0] carry_q;
  logic [SP_W-1:0]  sp_q;
  logic [IDX_W-1:0] clr_q;
  req_t             req_q;
  res_t             res_q;
  frame_t           stack_q [STACK_D];

  logic [POS_W:0]   sum;
  logic [POS_W-1:0] mid;
  logic [IDX_W-1:0] left, right;
  logic             miss, right_first;
  logic [VAL_W-1:0] upd;
  frame_t           top, push;

  assign sum         = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid         = sum[POS_W:1];
  assign left        = {node_q[IDX_W-2:0], 1'b0};
  assign right       = {node_q[IDX_W-2:0], 1'b1};
  assign right_first = (req_q.req_type == REQ_FIND_RIGHT);
  assign miss = (req_q.range_low > req_q.range_high) || (req_q.range_high < lo_q) ||
                (req_q.range_low > hi_q) || (rdata_i < req_q.threshold);
  assign upd  = (carry_q < rdata_i) ? rdata_i : carry_q;
  assign top  = stack_q[sp_q - SP_W'(1)];
  assign push = right_first ? frame_t'{node: left, lo: lo_q, hi: mid}
                            : frame_t'{node: right, lo: mid + POS_W'(1), hi: hi_q};

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESULT);
  assign res_o       = res_q;

  always_comb begin
    mem_o = '{we: 1'b0, waddr: node_q, wdata: req_q.write_value, raddr: node_q};
    unique case (state_q)
      S_CLEAR: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = clr_q;
        mem_o.wdata = '0;
      end
      S_WDESC: mem_o.we = (lo_q == hi_q);
      S_WREAD: mem_o.raddr = node_q ^ IDX_W'(1);
      S_WUPD: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = node_q >> 1;
        mem_o.wdata = upd;
      end
      default: ;
    endcase
  end

  // explicit search stack, written only on descent
  always_ff @(posedge clk_i) begin
    if (state_q == S_QCHECK && !miss && lo_q != hi_q) begin
      stack_q[sp_q] <= push;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      node_q  <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      carry_q <= '0;
      sp_q    <= '0;
      req_q   <= '0;
      res_q   <= '0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + IDX_W'(1);
          if (&clr_q) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid_i) begin
            req_q  <= req_i;
            node_q <= IDX_W'(1);
            lo_q   <= POS_W'(1);
            hi_q   <= span_i;
            sp_q   <= '0;
            unique case (req_i.req_type)
              REQ_WRITE: begin
                if (req_i.position != '0 && req_i.position <= span_i) begin
                  state_q <= S_WDESC;
                end
              end
              REQ_CLEAR: begin
                clr_q   <= '0;
                state_q <= S_CLEAR;
              end
              default: state_q <= S_QVISIT;
            endcase
          end
        end
        S_WDESC: begin
          if (lo_q == hi_q) begin
            carry_q <= req_q.write_value;
            state_q <= (node_q == IDX_W'(1)) ? S_IDLE : S_WREAD;
          end else if (req_q.position <= mid) begin
            node_q <= left;
            hi_q   <= mid;
          end else begin
            node_q <= right;
            lo_q   <= mid + POS_W'(1);
          end
        end
        S_WREAD: state_q <= S_WUPD;
        S_WUPD: begin
          carry_q <= upd;
          node_q  <= node_q >> 1;
          state_q <= (node_q[IDX_W-1:1] == (IDX_W-1)'(1)) ? S_IDLE : S_WREAD;
        end
        S_QVISIT: state_q <= S_QCHECK;
        S_QCHECK: begin
          if (miss) begin
            if (sp_q == '0) begin
              res_q   <= '0;
              state_q <= S_RESULT;
            end else begin
              node_q  <= top.node;
              lo_q    <= top.lo;
              hi_q    <= top.hi;
              sp_q    <= sp_q - SP_W'(1);
              state_q <= S_QVISIT;
            end
          end else if (lo_q == hi_q) begin
            res_q   <= '{found: 1'b1, found_position: lo_q};
            state_q <= S_RESULT;
          end else begin
            sp_q    <= sp_q + SP_W'(1);
            state_q <= S_QVISIT;
            if (right_first) begin
              node_q <= right;
              lo_q   <= mid + POS_W'(1);
            end else begin
              node_q <= left;
              hi_q   <= mid;
            end
          end
        end
        S_RESULT: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `MTTS_ASSERT_IMP(a_no_write_when_ready, mem_o.we, !req_ready_o, "store written while idle")
  `MTTS_ASSERT_IMP(a_hit_in_span, res_valid_o && res_o.found,
    res_o.found_position != '0 && res_o.found_position <= span_i, "hit outside span")
  `MTTS_ASSERT_IMP(a_miss_zero, res_valid_o && !res_o.found,
    res_o.found_position == '0, "miss with nonzero position")
  `MTTS_ASSERT(a_stack_bound, sp_q <= SP_W'(IDX_W - 1), "search stack overflow")

endmodule

// File: rtl/max_tree_threshold_search_unit.sv
// top level of the max tree threshold search unit
// depends on mtts_pkg, mtts_ram and mtts_ctrl
//
// channel   direction  payload          handshake
// in        request    req_t            in_valid_i / in_ready_o
// out       result     res_t            out_valid_o / out_ready_i
// cfg       write      used_size        cfg_valid_i / cfg_ready_o
//
// write: descend to the leaf and write it, then read the sibling and update the parent at each level up to the root
// query: each visited node is read (S_QVISIT) then compared (S_QCHECK); the result is handed over from S_RESULT
// clear and reset: a sweep over all 2048 entries zeroes the store, no request taken
// a finished result sits in the output register, so the next request goes in
// while it waits; a second result stalls the sequencer until out is drained
module max_tree_threshold_search_unit import mtts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  req_t             in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output res_t             out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [POS_W-1:0] cfg_data_i
);

  logic [POS_W-1:0] used_size_q;
  logic [POS_W-1:0] span;
  mem_req_t         mem_req;
  logic [VAL_W-1:0] rdata;
  logic             res_valid, res_ready;
  res_t             res;
  logic             out_valid_q;
  res_t             out_data_q;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_size_q <= POS_W'(LEAVES);
    end else if (cfg_valid_i) begin
      used_size_q <= cfg_data_i;
    end
  end

  // zero acts as one, anything above the leaf count is capped
  always_comb begin
    if (used_size_q == '0) begin
      span = POS_W'(1);
    end else if (used_size_q > POS_W'(LEAVES)) begin
      span = POS_W'(LEAVES);
    end else begin
      span = used_size_q;
    end
  end

  // node maxima store, heap indexed, entry 0 unused
  mtts_ram #(
    .Depth(TREE_SIZE),
    .Width(VAL_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_req.we),
    .waddr_i(mem_req.waddr),
    .wdata_i(mem_req.wdata),
    .raddr_i(mem_req.raddr),
    .rdata_o(rdata)
  );

  mtts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(in_valid_i),
    .req_ready_o(in_ready_o),
    .req_i      (in_data_i),
    .span_i     (span),
    .mem_o      (mem_req),
    .rdata_i    (rdata),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // output register decouples the result from the sequencer
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: sim/mtts_checker.sv
// checker for the max tree threshold search unit: watches request, result and
// config channels, keeps its own max tree, compares results; depends on mtts_pkg
module mtts_checker import mtts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  req_t             in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  res_t             out_data_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [POS_W-1:0] cfg_data_i,
  output int               fail_count_o,
  output int               pending_o
);

  localparam logic [31:0] MISS = 32'hFFFF_FFFF;

  logic [VAL_W-1:0] tree_max [TREE_SIZE];
  logic [POS_W-1:0] size_reg;
  res_t             answer_q [$];

  function automatic int unsigned span_end();
    if (size_reg < 1) return 1;
    if (size_reg > LEAVES) return LEAVES;
    return size_reg;
  endfunction

  function automatic logic [VAL_W-1:0] node_at(int unsigned u);
    return (u < TREE_SIZE) ? tree_max[u] : '0;
  endfunction

  function automatic void store_leaf(int unsigned u, int unsigned lo, int unsigned hi,
                                     int unsigned pos, logic [VAL_W-1:0] v);
    int unsigned mid;
    logic [VAL_W-1:0] l, r;
    if (u >= TREE_SIZE) return;
    if (lo == hi) begin
      tree_max[u] = v;
      return;
    end
    mid = (lo + hi) >> 1;
    if (pos <= mid) store_leaf(2*u, lo, mid, pos, v);
    else store_leaf(2*u+1, mid+1, hi, pos, v);
    l = node_at(2*u);
    r = node_at(2*u+1);
    tree_max[u] = (l < r) ? r : l;
  endfunction

  function automatic logic [31:0] search_hit(int unsigned u, int unsigned lo,
      int unsigned hi, int unsigned a, int unsigned b, logic [VAL_W-1:0] k, bit rightmost);
    int unsigned mid;
    logic [31:0] hit;
    if (a > b || b < lo || a > hi || node_at(u) < k) return MISS;
    if (lo == hi) return lo;
    mid = (lo + hi) >> 1;
    if (rightmost) begin
      hit = search_hit(2*u+1, mid+1, hi, a, b, k, 1);
      if (hit == MISS) hit = search_hit(2*u, lo, mid, a, b, k, 1);
    end else begin
      hit = search_hit(2*u, lo, mid, a, b, k, 0);
      if (hit == MISS) hit = search_hit(2*u+1, mid+1, hi, a, b, k, 0);
    end
    return hit;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;
  assign pending_o = answer_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    logic [31:0] hit;
    int unsigned n;
    if (!rst_ni) begin
      foreach (tree_max[i]) tree_max[i] = '0;
      size_reg = 11'd1024;
      answer_q.delete();
    end else begin
      // result side first: a result never belongs to a request taken this edge
      if (out_valid_i && out_ready_i) begin
        if (answer_q.size() == 0) report("unexpected result", out_data_i.found, -1);
        else begin
          want = answer_q.pop_front();
          if (out_data_i.found !== want.found)
            report("found", out_data_i.found, want.found);
          if (out_data_i.found_position !== want.found_position)
            report("found_position", out_data_i.found_position, want.found_position);
        end
      end
      if (cfg_valid_i && cfg_ready_i) size_reg = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        n = span_end();
        case (req_e'(in_data_i.req_type))
          REQ_WRITE: begin
            if (in_data_i.position >= 1 && in_data_i.position <= n)
              store_leaf(1, 1, n, in_data_i.position, in_data_i.write_value);
          end
          REQ_CLEAR: foreach (tree_max[i]) tree_max[i] = '0;
          default: begin
            hit = search_hit(1, 1, n, in_data_i.range_low, in_data_i.range_high,
                             in_data_i.threshold, in_data_i.req_type == REQ_FIND_RIGHT);
            want.found = (hit != MISS);
            want.found_position = (hit != MISS) ? hit[POS_W-1:0] : '0;
            answer_q.push_back(want);
          end
        endcase
      end
    end
  end

endmodule

// File: sim/testbench.sv
// top of the max tree threshold search unit testbench: clock, reset, stimulus
// and verdict; depends on mtts_pkg, the unit and mtts_checker
module testbench;
  import mtts_pkg::*;

  logic             clk_i = 0;
  logic             rst_ni = 0;
  logic             in_valid_i = 0;
  logic             in_ready_o;
  req_t             in_data_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 0;
  res_t             out_data_o;
  logic             cfg_valid_i = 0;
  logic             cfg_ready_o;
  logic [POS_W-1:0] cfg_data_i = '0;
  int               fail_count;
  int               pending;
  int               cycle_count = 0;
  bit               calm = 0;       // no idling while set

  localparam int CYCLE_LIMIT = 2_000_000;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  max_tree_threshold_search_unit DUT (.*);

  mtts_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // hard stop on a hang
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side stalls about 28 percent of the time, never while calm
  always @(negedge clk_i) out_ready_i <= calm || ($urandom_range(99) >= 28);

  // one request, held until taken; random gap beforehand unless calm
  task automatic send_request(req_t r);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 28) @(negedge clk_i);
    in_valid_i <= 1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i <= 0;
  endtask

  // config write only while idle; clear sweeps and write tails need to finish
  task automatic write_size(logic [POS_W-1:0] sz);
    while (pending != 0) @(negedge clk_i);
    repeat (2200) @(negedge clk_i);
    cfg_valid_i <= 1;
    cfg_data_i  <= sz;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  function automatic req_t make_req(req_e t, int pos, int val, int lo, int hi, int k);
    req_t r;
    r.req_type = t;
    r.position = POS_W'(pos);
    r.write_value = VAL_W'(val);
    r.range_low = POS_W'(lo);
    r.range_high = POS_W'(hi);
    r.threshold = VAL_W'(k);
    return r;
  endfunction

  // mostly in-span fields; sometimes anything the width allows
  function automatic int pick_pos(int n);
    case ($urandom_range(9))
      0: return $urandom_range(2047);
      1: return 0;
      2: return n;
      default: return $urandom_range(n, 1);
    endcase
  endfunction

  function automatic req_t random_req(int n);
    req_t r;
    int pick, lo, hi;
    pick = $urandom_range(99);
    r = req_t'({$urandom, $urandom, 3'($urandom)});
    lo = pick_pos(n);
    hi = pick_pos(n);
    if ($urandom_range(3) != 0 && lo > hi) begin
      r.range_low = POS_W'(hi); r.range_high = POS_W'(lo);
    end else begin
      r.range_low = POS_W'(lo); r.range_high = POS_W'(hi);
    end
    r.position = POS_W'(pick_pos(n));
    if ($urandom_range(3) == 0) r.threshold = VAL_W'($urandom_range(3));
    if (pick < 45) r.req_type = REQ_WRITE;
    else if (pick < 70) r.req_type = REQ_FIND_RIGHT;
    else if (pick < 98) r.req_type = REQ_FIND_LEFT;
    else r.req_type = REQ_CLEAR;
    return r;
  endfunction

  task automatic random_phase(int n, int count);
    repeat (count) send_request(random_req(n));
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1;

    // directed: extremes at reset size
    send_request(make_req(REQ_FIND_LEFT, 0, 0, 1, 1024, 0));     // zero threshold
    send_request(make_req(REQ_WRITE, 1, 16'hFFFF, 0, 0, 0));
    send_request(make_req(REQ_WRITE, 1024, 7, 0, 0, 0));
    send_request(make_req(REQ_WRITE, 0, 9, 0, 0, 0));            // ignored
    send_request(make_req(REQ_WRITE, 2047, 9, 0, 0, 0));         // beyond span
    send_request(make_req(REQ_WRITE, 512, 300, 2047, 2047, 16'hFFFF));
    send_request(make_req(REQ_FIND_RIGHT, 0, 0, 0, 2047, 7));
    send_request(make_req(REQ_FIND_LEFT, 0, 0, 0, 2047, 7));
    send_request(make_req(REQ_FIND_LEFT, 0, 0, 2, 1023, 301));
    send_request(make_req(REQ_FIND_RIGHT, 0, 0, 1, 1024, 16'hFFFF));
    send_request(make_req(REQ_FIND_LEFT, 0, 0, 600, 10, 0));     // empty range
    send_request(make_req(REQ_FIND_RIGHT, 0, 0, 1025, 1025, 0)); // out of span
    send_request(make_req(REQ_FIND_LEFT, 0, 0, 1024, 1024, 7));
    send_request(make_req(REQ_CLEAR, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_FIND_RIGHT, 0, 0, 1, 1024, 1));
    send_request(make_req(REQ_FIND_RIGHT, 0, 0, 1, 1024, 0));

    // long calm stretch, then normal idling
    calm = 1;
    random_phase(1024, 80);
    calm = 0;
    random_phase(1024, 120);

    // smallest span; store kept across resize
    write_size(1);
    send_request(make_req(REQ_FIND_LEFT, 0, 0, 0, 2, 0));
    random_phase(1, 60);
    write_size(0);                                                  // acts as one
    random_phase(1, 30);
    write_size(2047);                                               // acts as full
    random_phase(1024, 70);
    write_size(13);
    random_phase(13, 120);
    write_size(2);
    random_phase(2, 50);
    write_size(1000);
    random_phase(1000, 100);

    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// File: max_tree_threshold_search_unit.f
+incdir+rtl
rtl/mtts_pkg.sv
rtl/mtts_ram.sv
rtl/mtts_ctrl.sv
rtl/max_tree_threshold_search_unit.sv
sim/mtts_checker.sv
sim/testbench.sv
